[rtl/start_stop_coincidence_matcher_unit_defines.svh]
// Assertion macros used by the top RTL file of the coincidence matcher.
// Each macro takes a label, the clock, the active-low reset, a condition,
// the expected consequence and a message.
`ifndef START_STOP_COINCIDENCE_MATCHER_UNIT_DEFINES_SVH
`define START_STOP_COINCIDENCE_MATCHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define SSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/ssc_pkg.sv]
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int CH_IN_W     = 4;
    localparam int CHX_W       = 7;
    localparam int TIME_W      = 48;
    localparam int ENERGY_W    = 16;
    localparam int WORD_W      = TIME_W + ENERGY_W;
    localparam int WIN_W       = 32;
    localparam int PCNT_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int REG_PAIRS   = 2;
    localparam int RES_CNT_W   = 6;
    localparam int FRONT_DEPTH = 4;
    localparam int FQ_PTR_W    = 2;
    localparam int FQ_CNT_W    = 3;

    localparam logic [RES_CNT_W-1:0] RES_CNT_MAX = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P0_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_P0_STOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_START   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P1_STOP    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [WIN_W-1:0]   WINDOW_RST   = 32'd100;
    localparam logic [PCNT_W-1:0]  PCOUNT_RST   = 2'd0;
    localparam logic [CH_IN_W-1:0] P0_START_RST = 4'd0;
    localparam logic [CH_IN_W-1:0] P0_STOP_RST  = 4'd1;
    localparam logic [CH_IN_W-1:0] P1_START_RST = 4'd2;
    localparam logic [CH_IN_W-1:0] P1_STOP_RST  = 4'd3;

    typedef struct packed {
        logic [WIN_W-1:0]                    window;
        logic [PCNT_W-1:0]                   pair_count;
        logic [REG_PAIRS-1:0][CH_IN_W-1:0]   pair_start;
        logic [REG_PAIRS-1:0][CH_IN_W-1:0]   pair_stop;
    } t_cfg;

    typedef struct packed {
        logic [CH_IN_W-1:0]  hit_channel;
        logic [TIME_W-1:0]   hit_time;
        logic [ENERGY_W-1:0] hit_energy;
        logic                end_of_event;
        logic                ch_ok;
    } t_cmd;

    typedef struct packed {
        logic                pair_index;
        logic [ENERGY_W-1:0] start_energy;
        logic                last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PAIR,
        S_LDA,
        S_LDB,
        S_CHK,
        S_CMP,
        S_DEC,
        S_WBA,
        S_WBB,
        S_FLUSH
    } t_eng_state;

    typedef struct packed {
        logic                 busy;
        logic                 pend_v;
        logic [RES_CNT_W-1:0] res_cnt;
    } t_eng_status;

    typedef struct packed {
        logic [FQ_CNT_W-1:0] count;
    } t_front_status;

endpackage

[rtl/ssc_hit_if.sv]
`timescale 1ns / 1ps

interface ssc_hit_if;
    logic                         valid;
    logic                         ready;
    logic [ssc_pkg::CH_IN_W-1:0]  hit_channel;
    logic [ssc_pkg::TIME_W-1:0]   hit_time;
    logic [ssc_pkg::ENERGY_W-1:0] hit_energy;
    logic                         end_of_event;

    modport source (
        output valid, hit_channel, hit_time, hit_energy, end_of_event,
        input  ready
    );
    modport sink (
        input  valid, hit_channel, hit_time, hit_energy, end_of_event,
        output ready
    );
endinterface

[rtl/ssc_res_if.sv]
`timescale 1ns / 1ps

interface ssc_res_if;
    logic                         valid;
    logic                         ready;
    logic                         pair_index;
    logic [ssc_pkg::ENERGY_W-1:0] start_energy;
    logic                         last;

    modport source (
        output valid, pair_index, start_energy, last,
        input  ready
    );
    modport sink (
        input  valid, pair_index, start_energy, last,
        output ready
    );
endinterface

[rtl/ssc_front.sv]
`timescale 1ns / 1ps

module ssc_front #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ssc_hit_if.sink                 i_hit,
    output logic                    o_cmd_v,
    output ssc_pkg::t_cmd           o_cmd,
    input  logic                    i_cmd_rd,
    output ssc_pkg::t_front_status  o_status
);

    localparam int CHX_W = ssc_pkg::CHX_W;
    localparam int PTR_W = ssc_pkg::FQ_PTR_W;
    localparam int CNT_W = ssc_pkg::FQ_CNT_W;

    ssc_pkg::t_cmd      r_q [ssc_pkg::FRONT_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_push;
    logic               w_pop;
    logic               w_ch_ok;
    ssc_pkg::t_cmd      w_word;

    // Channels beyond the configured count are marked here and dropped later.
    assign w_ch_ok = CHX_W'(i_hit.hit_channel) < CHX_W'(NUM_CHANNELS);

    always_comb begin
        w_word.hit_channel  = i_hit.hit_channel;
        w_word.hit_time     = i_hit.hit_time;
        w_word.hit_energy   = i_hit.hit_energy;
        w_word.end_of_event = i_hit.end_of_event;
        w_word.ch_ok        = w_ch_ok;
    end

    assign i_hit.ready = (r_cnt != CNT_W'(ssc_pkg::FRONT_DEPTH));
    assign w_push      = i_hit.valid && i_hit.ready;
    assign w_pop       = i_cmd_rd && (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_word;
        end
    end

    assign o_cmd_v        = (r_cnt != '0);
    assign o_cmd          = r_q[r_rp];
    assign o_status.count = r_cnt;

endmodule

[rtl/ssc_engine.sv]
`timescale 1ns / 1ps

module ssc_engine #(
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_PAIRS    = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssc_pkg::t_cfg         i_cfg,
    input  logic                  i_cmd_v,
    input  ssc_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_rd,
    input  logic                  i_out_free,
    output logic                  o_res_v,
    output ssc_pkg::t_res         o_res,
    output ssc_pkg::t_eng_status  o_status
);

    localparam int CH_W       = $clog2(NUM_CHANNELS);
    localparam int Q_W        = $clog2(QUEUE_DEPTH);
    localparam int F_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int A_W        = $clog2(NUM_CHANNELS * QUEUE_DEPTH);
    localparam int CHX_W      = ssc_pkg::CHX_W;
    localparam int TIME_W     = ssc_pkg::TIME_W;
    localparam int ENERGY_W   = ssc_pkg::ENERGY_W;
    localparam int WORD_W     = ssc_pkg::WORD_W;
    localparam int PCNT_W     = ssc_pkg::PCNT_W;
    localparam int RCNT_W     = ssc_pkg::RES_CNT_W;
    localparam int PAIR_LIMIT = (NUM_PAIRS < ssc_pkg::REG_PAIRS) ? NUM_PAIRS
                                                                 : ssc_pkg::REG_PAIRS;

    function automatic logic [Q_W-1:0] f_inc(input logic [Q_W-1:0] ptr);
        f_inc = (ptr == Q_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    function automatic logic [A_W-1:0] f_addr(input logic [CH_W-1:0] ch,
                                             input logic [Q_W-1:0]  ptr);
        f_addr = A_W'(ch) * A_W'(QUEUE_DEPTH) + A_W'(ptr);
    endfunction

    // Hit store: one block of QUEUE_DEPTH words per channel.
    logic [WORD_W-1:0]      r_store [NUM_CHANNELS * QUEUE_DEPTH];
    logic [WORD_W-1:0]      r_rd_a;
    logic [WORD_W-1:0]      r_rd_b;

    logic [Q_W-1:0]         r_head [NUM_CHANNELS];
    logic [Q_W-1:0]         r_tail [NUM_CHANNELS];
    logic [F_W-1:0]         r_fill [NUM_CHANNELS];

    ssc_pkg::t_eng_state    r_state, n_state;
    ssc_pkg::t_cmd          r_cmd, n_cmd;
    logic [PCNT_W-1:0]      r_p, n_p;
    logic [RCNT_W-1:0]      r_n, n_n;
    logic [CH_W-1:0]        r_sa, n_sa;
    logic [CH_W-1:0]        r_so, n_so;
    logic [Q_W-1:0]         r_ha, n_ha;
    logic [Q_W-1:0]         r_hb, n_hb;
    logic [F_W-1:0]         r_fa, n_fa;
    logic [F_W-1:0]         r_fb, n_fb;
    logic [TIME_W-1:0]      r_diff, n_diff;
    logic                   r_a_less, n_a_less;
    logic                   r_pend_v, n_pend_v;
    ssc_pkg::t_res          r_pend, n_pend;

    logic [CHX_W-1:0]       w_cmd_chx;
    logic [CHX_W-1:0]       w_sa_chx;
    logic [CHX_W-1:0]       w_so_chx;
    logic [CH_W-1:0]        w_cmd_ch;
    logic [PCNT_W-1:0]      w_active;
    logic                   w_pairs_done;
    logic                   w_pair_ok;
    logic                   w_cap_hit;
    logic                   w_heads_gone;
    logic                   w_match;
    logic                   w_stall;
    logic [TIME_W-1:0]      w_ts;
    logic [TIME_W-1:0]      w_to;

    logic [CH_W-1:0]        w_rd_ch;
    logic [CH_W-1:0]        w_wr_ch;
    logic                   w_head_we;
    logic                   w_tail_we;
    logic                   w_fill_we;
    logic [Q_W-1:0]         w_head_wd;
    logic [Q_W-1:0]         w_tail_wd;
    logic [F_W-1:0]         w_fill_wd;
    logic                   w_mem_we;
    logic [A_W-1:0]         w_mem_waddr;

    assign w_cmd_chx = CHX_W'(r_cmd.hit_channel);
    assign w_cmd_ch  = w_cmd_chx[CH_W-1:0];
    assign w_sa_chx  = CHX_W'(i_cfg.pair_start[r_p[0]]);
    assign w_so_chx  = CHX_W'(i_cfg.pair_stop[r_p[0]]);

    assign w_active = (i_cfg.pair_count > PCNT_W'(PAIR_LIMIT)) ? PCNT_W'(PAIR_LIMIT)
                                                               : i_cfg.pair_count;
    assign w_cap_hit    = (r_n >= ssc_pkg::RES_CNT_MAX);
    assign w_pairs_done = (r_p >= w_active) || w_cap_hit;
    // A pair naming a missing channel, or the same channel twice, is skipped.
    assign w_pair_ok    = (w_sa_chx < CHX_W'(NUM_CHANNELS)) &&
                          (w_so_chx < CHX_W'(NUM_CHANNELS)) &&
                          (w_sa_chx != w_so_chx);
    assign w_heads_gone = (r_fa == '0) || (r_fb == '0) || w_cap_hit;

    assign w_ts    = r_rd_a[WORD_W-1:ENERGY_W];
    assign w_to    = r_rd_b[WORD_W-1:ENERGY_W];
    assign w_match = r_diff < TIME_W'(i_cfg.window);
    // A new match can only be parked once the previous one has left.
    assign w_stall = w_match && r_pend_v && !i_out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssc_pkg::S_IDLE: begin
                if (i_cmd_v) begin
                    n_state = ssc_pkg::S_PUSH;
                end
            end
            ssc_pkg::S_PUSH: begin
                n_state = r_cmd.end_of_event ? ssc_pkg::S_PAIR : ssc_pkg::S_IDLE;
            end
            ssc_pkg::S_PAIR: begin
                if (w_pairs_done) begin
                    n_state = ssc_pkg::S_FLUSH;
                end else if (w_pair_ok) begin
                    n_state = ssc_pkg::S_LDA;
                end
            end
            ssc_pkg::S_LDA: n_state = ssc_pkg::S_LDB;
            ssc_pkg::S_LDB: n_state = ssc_pkg::S_CHK;
            ssc_pkg::S_CHK: begin
                n_state = w_heads_gone ? ssc_pkg::S_WBA : ssc_pkg::S_CMP;
            end
            ssc_pkg::S_CMP: n_state = ssc_pkg::S_DEC;
            ssc_pkg::S_DEC: begin
                if (!w_stall) begin
                    n_state = ssc_pkg::S_CHK;
                end
            end
            ssc_pkg::S_WBA: n_state = ssc_pkg::S_WBB;
            ssc_pkg::S_WBB: n_state = ssc_pkg::S_PAIR;
            ssc_pkg::S_FLUSH: begin
                if (!r_pend_v || i_out_free) begin
                    n_state = ssc_pkg::S_IDLE;
                end
            end
            default: n_state = ssc_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cmd       = r_cmd;
        n_p         = r_p;
        n_n         = r_n;
        n_sa        = r_sa;
        n_so        = r_so;
        n_ha        = r_ha;
        n_hb        = r_hb;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_diff      = r_diff;
        n_a_less    = r_a_less;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        o_cmd_rd    = 1'b0;
        o_res_v     = 1'b0;
        o_res       = r_pend;
        w_rd_ch     = r_sa;
        w_wr_ch     = r_sa;
        w_head_we   = 1'b0;
        w_tail_we   = 1'b0;
        w_fill_we   = 1'b0;
        w_head_wd   = r_ha;
        w_tail_wd   = f_inc(r_tail[w_rd_ch]);
        w_fill_wd   = r_fa;
        w_mem_we    = 1'b0;
        w_mem_waddr = f_addr(w_cmd_ch, r_tail[w_cmd_ch]);

        case (r_state)
            ssc_pkg::S_IDLE: begin
                if (i_cmd_v) begin
                    o_cmd_rd = 1'b1;
                    n_cmd    = i_cmd;
                end
            end
            ssc_pkg::S_PUSH: begin
                w_rd_ch = w_cmd_ch;
                w_wr_ch = w_cmd_ch;
                n_p     = '0;
                n_n     = '0;
                // A hit for a full queue is dropped.
                if (r_cmd.ch_ok && (r_fill[w_rd_ch] != F_W'(QUEUE_DEPTH))) begin
                    w_mem_we  = 1'b1;
                    w_tail_we = 1'b1;
                    w_fill_we = 1'b1;
                    w_tail_wd = f_inc(r_tail[w_cmd_ch]);
                    w_fill_wd = r_fill[w_rd_ch] + 1'b1;
                end
            end
            ssc_pkg::S_PAIR: begin
                if (!w_pairs_done) begin
                    if (w_pair_ok) begin
                        n_sa = w_sa_chx[CH_W-1:0];
                        n_so = w_so_chx[CH_W-1:0];
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end
            end
            ssc_pkg::S_LDA: begin
                w_rd_ch = r_sa;
                n_ha    = r_head[w_rd_ch];
                n_fa    = r_fill[w_rd_ch];
            end
            ssc_pkg::S_LDB: begin
                w_rd_ch = r_so;
                n_hb    = r_head[w_rd_ch];
                n_fb    = r_fill[w_rd_ch];
            end
            ssc_pkg::S_CMP: begin
                n_a_less = w_ts < w_to;
                n_diff   = (w_ts < w_to) ? (w_to - w_ts) : (w_ts - w_to);
            end
            ssc_pkg::S_DEC: begin
                if (w_match) begin
                    if (!w_stall) begin
                        // The parked match is not the last one: send it on.
                        o_res_v             = r_pend_v;
                        o_res.last          = 1'b0;
                        n_pend_v            = 1'b1;
                        n_pend.pair_index   = r_p[0];
                        n_pend.start_energy = r_rd_a[ENERGY_W-1:0];
                        n_pend.last         = 1'b0;
                        n_n                 = r_n + 1'b1;
                        n_ha                = f_inc(r_ha);
                        n_fa                = r_fa - 1'b1;
                        n_hb                = f_inc(r_hb);
                        n_fb                = r_fb - 1'b1;
                    end
                end else if (r_a_less) begin
                    n_ha = f_inc(r_ha);
                    n_fa = r_fa - 1'b1;
                end else begin
                    n_hb = f_inc(r_hb);
                    n_fb = r_fb - 1'b1;
                end
            end
            ssc_pkg::S_WBA: begin
                w_wr_ch   = r_sa;
                w_head_we = 1'b1;
                w_fill_we = 1'b1;
                w_head_wd = r_ha;
                w_fill_wd = r_fa;
            end
            ssc_pkg::S_WBB: begin
                w_wr_ch   = r_so;
                w_head_we = 1'b1;
                w_fill_we = 1'b1;
                w_head_wd = r_hb;
                w_fill_wd = r_fb;
                n_p       = r_p + 1'b1;
            end
            ssc_pkg::S_FLUSH: begin
                if (r_pend_v && i_out_free) begin
                    o_res_v    = 1'b1;
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ssc_pkg::S_IDLE;
            r_p      <= '0;
            r_n      <= '0;
            r_pend_v <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_p      <= n_p;
            r_n      <= n_n;
            r_pend_v <= n_pend_v;
            if (w_head_we) begin
                r_head[w_wr_ch] <= w_head_wd;
            end
            if (w_tail_we) begin
                r_tail[w_wr_ch] <= w_tail_wd;
            end
            if (w_fill_we) begin
                r_fill[w_wr_ch] <= w_fill_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sa     <= n_sa;
        r_so     <= n_so;
        r_ha     <= n_ha;
        r_hb     <= n_hb;
        r_fa     <= n_fa;
        r_fb     <= n_fb;
        r_diff   <= n_diff;
        r_a_less <= n_a_less;
        r_pend   <= n_pend;
    end

    // Store: one write port, two registered read ports for the two heads.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_waddr] <= {r_cmd.hit_time, r_cmd.hit_energy};
        end
        r_rd_a <= r_store[f_addr(r_sa, r_ha)];
        r_rd_b <= r_store[f_addr(r_so, r_hb)];
    end

    assign o_status.busy    = (r_state != ssc_pkg::S_IDLE);
    assign o_status.pend_v  = r_pend_v;
    assign o_status.res_cnt = r_n;

endmodule

[rtl/start_stop_coincidence_matcher_unit.sv]
`timescale 1ns / 1ps
`include "start_stop_coincidence_matcher_unit_defines.svh"

// Start/stop coincidence matcher.
// i_hit takes one hit word per valid/ready handshake: channel, 48-bit
// timestamp, energy and an end-of-event flag. Hits are queued per channel.
// On a hit with end_of_event set, each active start/stop pair compares its
// queue heads and o_res delivers one word per coincidence, at most 32 per
// event, carrying the pair index and the start energy; last marks the final
// word of that event. Configuration must be written through i_cfg_we /
// i_cfg_idx / i_cfg_data only while the block is idle; the block itself does
// not enforce this. Steps: a hit that does not end an event passes the idle
// and push states of the matching engine. At event end each pair enters the
// pair state, loads both queue heads, repeats a check, compare and decide
// step per head comparison, reading the heads from the registered store
// ports, and writes both heads back; a skipped pair only passes the pair
// state, and a flush state closes the event and sends the final word. A
// 4-word queue in front of the engine keeps taking hits while the engine is
// matching. Reset clears all queues and loads the register defaults; there
// is no clearing pass. If o_res stalls, the engine holds its next match and
// stops; the input queue then fills and i_hit.ready drops.
module start_stop_coincidence_matcher_unit #(
    parameter int NUM_CHANNELS = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int NUM_PAIRS    = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ssc_hit_if.sink                            i_hit,
    ssc_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int WIN_W   = ssc_pkg::WIN_W;
    localparam int PCNT_W  = ssc_pkg::PCNT_W;
    localparam int CH_IN_W = ssc_pkg::CH_IN_W;

    ssc_pkg::t_cfg           r_cfg;
    logic                    r_out_v;
    ssc_pkg::t_res           r_out;
    logic                    w_out_free;
    logic                    w_cmd_v;
    ssc_pkg::t_cmd           w_cmd;
    logic                    w_cmd_rd;
    logic                    w_eng_v;
    ssc_pkg::t_res           w_eng_res;
    ssc_pkg::t_eng_status    w_eng_st;
    ssc_pkg::t_front_status  w_front_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window        <= ssc_pkg::WINDOW_RST;
            r_cfg.pair_count    <= ssc_pkg::PCOUNT_RST;
            r_cfg.pair_start[0] <= ssc_pkg::P0_START_RST;
            r_cfg.pair_stop[0]  <= ssc_pkg::P0_STOP_RST;
            r_cfg.pair_start[1] <= ssc_pkg::P1_START_RST;
            r_cfg.pair_stop[1]  <= ssc_pkg::P1_STOP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssc_pkg::CFG_WINDOW:     r_cfg.window        <= i_cfg_data[WIN_W-1:0];
                ssc_pkg::CFG_PAIR_COUNT: r_cfg.pair_count    <= i_cfg_data[PCNT_W-1:0];
                ssc_pkg::CFG_P0_START:   r_cfg.pair_start[0] <= i_cfg_data[CH_IN_W-1:0];
                ssc_pkg::CFG_P0_STOP:    r_cfg.pair_stop[0]  <= i_cfg_data[CH_IN_W-1:0];
                ssc_pkg::CFG_P1_START:   r_cfg.pair_start[1] <= i_cfg_data[CH_IN_W-1:0];
                ssc_pkg::CFG_P1_STOP:    r_cfg.pair_stop[1]  <= i_cfg_data[CH_IN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ssc_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hit    (i_hit),
        .o_cmd_v  (w_cmd_v),
        .o_cmd    (w_cmd),
        .i_cmd_rd (w_cmd_rd),
        .o_status (w_front_st)
    );

    ssc_engine #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .NUM_PAIRS    (NUM_PAIRS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_v    (w_cmd_v),
        .i_cmd      (w_cmd),
        .o_cmd_rd   (w_cmd_rd),
        .i_out_free (w_out_free),
        .o_res_v    (w_eng_v),
        .o_res      (w_eng_res),
        .o_status   (w_eng_st)
    );

    // Output register: the engine may hand over a word whenever it is empty
    // or being drained in this cycle.
    assign w_out_free = !r_out_v || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v <= w_eng_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_eng_v) begin
            r_out <= w_eng_res;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.pair_index   = r_out.pair_index;
    assign o_res.start_energy = r_out.start_energy;
    assign o_res.last         = r_out.last;

    `SSC_ASSERT_IMPL(a_pend_only_busy, i_clk, i_rst_n, w_eng_st.pend_v, w_eng_st.busy, "held match while engine idle")
    `SSC_ASSERT_IMPL(a_result_cap, i_clk, i_rst_n, w_eng_st.busy, w_eng_st.res_cnt <= ssc_pkg::RES_CNT_MAX, "result count over limit")
    `SSC_ASSERT_NEXT(a_hit_kept, i_clk, i_rst_n, i_hit.valid && i_hit.ready, (w_front_st.count != 0) || w_eng_st.busy, "accepted hit lost")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int NUM_CH    = 16;
    localparam int QDEPTH    = 16;
    localparam int MAX_COIN  = 32;
    // Enough for the engine to finish an event that produces nothing.
    localparam int SETTLE    = 500;

    typedef struct packed {
        logic [ssc_pkg::CH_IN_W-1:0]  ch;
        logic [ssc_pkg::TIME_W-1:0]   stamp;
        logic [ssc_pkg::ENERGY_W-1:0] energy;
        logic                         eoe;
    } t_hit;

    typedef struct packed {
        logic [ssc_pkg::TIME_W-1:0]   stamp;
        logic [ssc_pkg::ENERGY_W-1:0] energy;
    } t_stored_hit;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ssc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ssc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ssc_hit_if hit_bus ();
    ssc_res_if res_bus ();

    start_stop_coincidence_matcher_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hit      (hit_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the per-channel hit queues and of the registers.
    t_stored_hit                  hit_mem [NUM_CH][QDEPTH];
    int unsigned                  fifo_head [NUM_CH];
    int unsigned                  fifo_fill [NUM_CH];
    logic [ssc_pkg::WIN_W-1:0]    cfg_window;
    logic [ssc_pkg::PCNT_W-1:0]   cfg_pairs;
    logic [ssc_pkg::CH_IN_W-1:0]  cfg_start [ssc_pkg::REG_PAIRS];
    logic [ssc_pkg::CH_IN_W-1:0]  cfg_stop [ssc_pkg::REG_PAIRS];

    t_hit          hit_pending [$];
    ssc_pkg::t_res coin_due [$];
    t_hit          nxt_hit;
    int unsigned   hits_queued = 0;
    int unsigned   hits_taken = 0;
    int unsigned   coin_seen = 0;
    int unsigned   setups = 0;
    int unsigned   errors = 0;
    int unsigned   hit_wait = 0;
    int unsigned   res_wait = 0;
    bit            hit_idle_on = 0;
    bit            res_stall_on = 0;
    logic          hit_fire = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void drop_head(int unsigned ch);
        if (fifo_fill[ch] != 0) begin
            fifo_head[ch] = (fifo_head[ch] + 1) % QDEPTH;
            fifo_fill[ch]--;
        end
    endfunction

    // Queues the hit on its channel and, at event end, walks the active
    // pairs and records every coincidence word the block must deliver.
    function automatic void queue_and_match(t_hit h);
        int unsigned                slot, sa, so, n, active;
        logic [ssc_pkg::TIME_W-1:0] t_a, t_b, gap;
        ssc_pkg::t_res              r;
        n = 0;
        if (fifo_fill[h.ch] < QDEPTH) begin
            slot = (fifo_head[h.ch] + fifo_fill[h.ch]) % QDEPTH;
            hit_mem[h.ch][slot] = '{h.stamp, h.energy};
            fifo_fill[h.ch]++;
        end
        if (!h.eoe)
            return;
        active = (cfg_pairs > ssc_pkg::REG_PAIRS) ? ssc_pkg::REG_PAIRS : cfg_pairs;
        for (int p = 0; p < active; p++) begin
            sa = cfg_start[p];
            so = cfg_stop[p];
            if (sa != so) begin
                while (fifo_fill[sa] > 0 && fifo_fill[so] > 0 && n < MAX_COIN) begin
                    t_a = hit_mem[sa][fifo_head[sa]].stamp;
                    t_b = hit_mem[so][fifo_head[so]].stamp;
                    gap = (t_a > t_b) ? t_a - t_b : t_b - t_a;
                    if ({16'd0, gap} < {32'd0, cfg_window}) begin
                        r.pair_index   = p[0];
                        r.start_energy = hit_mem[sa][fifo_head[sa]].energy;
                        r.last         = 1'b0;
                        coin_due       = {coin_due, r};
                        n++;
                        drop_head(sa);
                        drop_head(so);
                    end else if (t_a < t_b) begin
                        drop_head(sa);
                    end else begin
                        drop_head(so);
                    end
                end
            end
        end
        if (n > 0) begin
            r = coin_due[coin_due.size() - 1];
            r.last = 1'b1;
            coin_due[coin_due.size() - 1] = r;
        end
    endfunction

    function automatic void queue_hit(input logic [ssc_pkg::CH_IN_W-1:0] ch,
                                      input logic [ssc_pkg::TIME_W-1:0] stamp,
                                      input logic [ssc_pkg::ENERGY_W-1:0] energy,
                                      input logic eoe);
        t_hit h;
        h = '{ch, stamp, energy, eoe};
        hit_pending = {hit_pending, h};
        hits_queued++;
    endfunction

    task automatic write_reg(input logic [ssc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            ssc_pkg::CFG_WINDOW:     cfg_window   = val;
            ssc_pkg::CFG_PAIR_COUNT: cfg_pairs    = val[ssc_pkg::PCNT_W-1:0];
            ssc_pkg::CFG_P0_START:   cfg_start[0] = val[ssc_pkg::CH_IN_W-1:0];
            ssc_pkg::CFG_P0_STOP:    cfg_stop[0]  = val[ssc_pkg::CH_IN_W-1:0];
            ssc_pkg::CFG_P1_START:   cfg_start[1] = val[ssc_pkg::CH_IN_W-1:0];
            ssc_pkg::CFG_P1_STOP:    cfg_stop[1]  = val[ssc_pkg::CH_IN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_setup(input logic [31:0] win, input logic [31:0] pairs,
                              input logic [31:0] s0, input logic [31:0] e0,
                              input logic [31:0] s1, input logic [31:0] e1);
        write_reg(ssc_pkg::CFG_WINDOW, win);
        write_reg(ssc_pkg::CFG_PAIR_COUNT, pairs);
        write_reg(ssc_pkg::CFG_P0_START, s0);
        write_reg(ssc_pkg::CFG_P0_STOP, e0);
        write_reg(ssc_pkg::CFG_P1_START, s1);
        write_reg(ssc_pkg::CFG_P1_STOP, e1);
        i_cfg_we <= 1'b0;
        setups++;
    endtask

    task automatic wait_idle();
        while (hits_taken != hits_queued || coin_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Mostly complete events on the configured channels, with times spread
    // around the window; the rest are stray hits and events left unclosed.
    task automatic random_hits(input int budget);
        int unsigned                  kind, len, hot_n, active;
        logic [ssc_pkg::CH_IN_W-1:0]  hot [4];
        logic [ssc_pkg::CH_IN_W-1:0]  c;
        logic [ssc_pkg::TIME_W-1:0]   base, spread;
        logic [63:0]                  raw, raw2;
        hot_n = 0;
        active = (cfg_pairs > ssc_pkg::REG_PAIRS) ? ssc_pkg::REG_PAIRS : cfg_pairs;
        for (int p = 0; p < active; p++) begin
            hot[hot_n] = cfg_start[p];
            hot[hot_n + 1] = cfg_stop[p];
            hot_n += 2;
        end
        if (cfg_window == 0)
            spread = 3;
        else if (cfg_window < 1_000_000)
            spread = {cfg_window, 1'b0};
        else
            spread = cfg_window;
        while (budget > 0) begin
            kind = $urandom_range(0, 9);
            raw  = {$urandom, $urandom};
            raw2 = {$urandom, $urandom};
            if (kind == 0) begin
                queue_hit(raw2[3:0], raw[47:0], raw[63:48], raw2[4]);
                budget--;
            end else begin
                base = raw[47:0];
                len  = $urandom_range(1, 8);
                if (len > budget)
                    len = budget;
                for (int i = 0; i < len; i++) begin
                    raw  = {$urandom, $urandom};
                    raw2 = {$urandom, $urandom};
                    if (hot_n > 0 && $urandom_range(0, 4) != 0)
                        c = hot[$urandom_range(0, hot_n - 1)];
                    else
                        c = raw2[3:0];
                    queue_hit(c, base + raw[47:0] % (spread + 1), raw[63:48],
                              kind != 1 && i == len - 1);
                end
                budget -= len;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!hit_bus.valid || hit_fire) begin
            if (hit_wait > 0) begin
                hit_wait--;
                hit_bus.valid <= 1'b0;
            end else if (hit_pending.size() > 0) begin
                nxt_hit = hit_pending.pop_front();
                hit_bus.hit_channel  <= nxt_hit.ch;
                hit_bus.hit_time     <= nxt_hit.stamp;
                hit_bus.hit_energy   <= nxt_hit.energy;
                hit_bus.end_of_event <= nxt_hit.eoe;
                hit_bus.valid        <= 1'b1;
                hit_wait = hit_idle_on ? pick_gap() : 0;
            end else begin
                hit_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (res_wait > 0) begin
            res_wait--;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
            if (res_stall_on && $urandom_range(0, 3) == 0)
                res_wait = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        ssc_pkg::t_res due;
        hit_fire <= hit_bus.valid && hit_bus.ready;
        if (i_rst_n && hit_bus.valid && hit_bus.ready) begin
            queue_and_match('{hit_bus.hit_channel, hit_bus.hit_time,
                              hit_bus.hit_energy, hit_bus.end_of_event});
            hits_taken++;
        end
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            coin_seen++;
            if (coin_due.size() == 0) begin
                $error("unexpected word: pair_index=%0d start_energy=%h last=%0d",
                       res_bus.pair_index, res_bus.start_energy, res_bus.last);
                errors++;
            end else begin
                due = coin_due.pop_front();
                if (res_bus.pair_index !== due.pair_index) begin
                    $error("pair_index: expected %0d, actual %0d",
                           due.pair_index, res_bus.pair_index);
                    errors++;
                end
                if (res_bus.start_energy !== due.start_energy) begin
                    $error("start_energy: expected %h, actual %h",
                           due.start_energy, res_bus.start_energy);
                    errors++;
                end
                if (res_bus.last !== due.last) begin
                    $error("last: expected %0d, actual %0d", due.last, res_bus.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [63:0]                raw;
        logic [ssc_pkg::TIME_W-1:0] base;
        int unsigned                s0, s1;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        hit_bus.valid        = 1'b0;
        hit_bus.hit_channel  = '0;
        hit_bus.hit_time     = '0;
        hit_bus.hit_energy   = '0;
        hit_bus.end_of_event = 1'b0;
        res_bus.ready        = 1'b0;
        cfg_window           = ssc_pkg::WINDOW_RST;
        cfg_pairs            = ssc_pkg::PCOUNT_RST;
        cfg_start[0]         = ssc_pkg::P0_START_RST;
        cfg_stop[0]          = ssc_pkg::P0_STOP_RST;
        cfg_start[1]         = ssc_pkg::P1_START_RST;
        cfg_stop[1]          = ssc_pkg::P1_STOP_RST;
        for (int c = 0; c < NUM_CH; c++) begin
            fifo_head[c] = 0;
            fifo_fill[c] = 0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Out of reset no pair is active, so an event end yields nothing.
        queue_hit(4'd0, 48'd5, 16'hFFFF, 1'b0);
        queue_hit(4'd1, 48'd50, 16'h0000, 1'b1);
        wait_idle();

        // A pair count of three is limited to the two register pairs.
        hit_idle_on  = 1;
        res_stall_on = 1;
        load_setup(ssc_pkg::WINDOW_RST, 3, 0, 1, 2, 3);
        queue_hit(4'd1, 48'd200, 16'h1234, 1'b0);
        queue_hit(4'd0, 48'd130, 16'h8001, 1'b1);
        queue_hit(4'd2, 48'hFFFF_FFFF_FFFF, 16'hA5A5, 1'b0);
        queue_hit(4'd3, 48'd0, 16'h0001, 1'b0);
        queue_hit(4'd3, 48'hFFFF_FFFF_FFF5, 16'h0002, 1'b1);
        // A difference equal to the window is not a coincidence.
        queue_hit(4'd0, 48'd1000, 16'h0011, 1'b0);
        queue_hit(4'd1, 48'd1100, 16'h0022, 1'b1);
        queue_hit(4'd0, 48'd2000, 16'h0033, 1'b0);
        queue_hit(4'd1, 48'd2099, 16'h0044, 1'b1);
        wait_idle();

        // A zero window never matches; equal times pop the stop head.
        load_setup(0, 1, 15, 14, 2, 3);
        queue_hit(4'd15, 48'd77, 16'hFFFF, 1'b0);
        queue_hit(4'd14, 48'd77, 16'h0000, 1'b1);
        wait_idle();

        // Widest window; the second pair uses one channel for both roles.
        load_setup(32'hFFFF_FFFF, 2, 15, 14, 5, 5);
        queue_hit(4'd5, 48'd9, 16'h0003, 1'b0);
        queue_hit(4'd15, 48'hFFFF_FFFF_FFFC, 16'h0009, 1'b0);
        queue_hit(4'd14, 48'hFFFF_FFFF_FFFF, 16'h0007, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            hit_idle_on  = ph[0];
            res_stall_on = ph[1] | ph[2];
            s0 = $urandom_range(0, 15);
            s1 = $urandom_range(0, 15);
            case (ph)
                0: load_setup($urandom_range(1, 2000), 2, s0, (s0 + $urandom_range(1, 15)) % 16,
                              s1, (s1 + $urandom_range(1, 15)) % 16);
                1: load_setup(32'hFFFF_FFFF, 1, s0, (s0 + $urandom_range(1, 15)) % 16, s1, s0);
                2: load_setup(1000, 2, 6, 7, 8, 9);
                3: load_setup(0, 2, s0, (s0 + $urandom_range(1, 15)) % 16,
                              s1, (s1 + $urandom_range(1, 15)) % 16);
                4: load_setup($urandom, $urandom_range(0, 3), $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 15));
                5: load_setup($urandom_range(1, 50), 3, s0, (s0 + $urandom_range(1, 15)) % 16,
                              s1, (s1 + $urandom_range(1, 15)) % 16);
                default: load_setup($urandom_range(100, 100000), 2, s0,
                                    (s0 + $urandom_range(1, 15)) % 16,
                                    s1, (s1 + $urandom_range(1, 15)) % 16);
            endcase
            if (ph == 2) begin
                // Overfill four queues with aligned hits: the extra hits are
                // dropped and the single event end yields a full burst of words.
                raw  = {$urandom, $urandom};
                base = raw[47:0];
                for (int i = 0; i < 18; i++) begin
                    for (int c = 6; c < 10; c++) begin
                        raw = {$urandom, $urandom};
                        queue_hit(ssc_pkg::CH_IN_W'(c), base + ssc_pkg::TIME_W'(i * 5000),
                                  raw[15:0], i == 17 && c == 9);
                    end
                end
            end else begin
                random_hits(30);
            end
            wait_idle();
        end

        $display("Run covered %0d hits and %0d coincidence words under %0d register setups.",
                 hits_taken, coin_seen, setups);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_hit_if.sv
rtl/ssc_res_if.sv
rtl/ssc_front.sv
rtl/ssc_engine.sv
rtl/start_stop_coincidence_matcher_unit.sv
tb/tb.sv
